>>> sv/latency_histogram_core_defines.svh
// ----------------------------------------------------------------------------
// latency_histogram_core_defines.svh
// Assertion macros shared by the latency histogram RTL.
// ----------------------------------------------------------------------------
`ifndef LATENCY_HISTOGRAM_CORE_DEFINES_SVH
`define LATENCY_HISTOGRAM_CORE_DEFINES_SVH

// Property checked at every rising clock edge outside reset
`define LH_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next
`define LH_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/lhist_pkg.sv
// ----------------------------------------------------------------------------
// lhist_pkg
// Sizes, codes and shared types of the latency histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lhist_pkg;

    // Histogram geometry
    localparam int NUM_BUCKETS  = 256;
    localparam int BUCKET_WIDTH = 10;
    localparam int DATA_W       = 32;
    localparam int ADDR_W       = $clog2(NUM_BUCKETS);

    // Samples at or above LIMIT always land in the last bucket, so the
    // quotient is only needed for values below it (LIM_W bits).
    localparam longint unsigned LIMIT =
        longint'(BUCKET_WIDTH) * longint'(NUM_BUCKETS - 1);
    localparam int LIM_W = ($clog2(LIMIT) < 1) ? 1 : $clog2(LIMIT);

    // Reciprocal multiply: q = (x * RECIP) >> SHIFT, exact for x < 2**LIM_W
    localparam int SHIFT = LIM_W + $clog2(BUCKET_WIDTH);
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + longint'(BUCKET_WIDTH) - 64'd1) / longint'(BUCKET_WIDTH);
    localparam int RECIP_W = LIM_W + 2;
    localparam int PROD_W  = LIM_W + RECIP_W;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Action codes on the input
    localparam logic [1:0] ACT_LOG   = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // Decoded operation
    typedef enum logic [1:0] {
        OP_LOG,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } t_op;

    // Classified command handed from front to back
    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] sample;
        logic              hit;
        logic              last;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [DATA_W-1:0] count;
        logic              last;
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] peak;
    } t_res;

endpackage

`default_nettype wire

>>> sv/latency_histogram_core.sv
// ----------------------------------------------------------------------------
// latency_histogram_core
// Histogram of latency samples in clamped buckets, with total and maximum.
// Every item gives one result. A log item goes to bucket sample/BUCKET_WIDTH,
// clamped to the last bucket; a clear empties all buckets, the total and the
// maximum in one step (buckets carry valid flops, so there is no clearing
// pass after reset or clear); a read returns one bucket. The front stage
// decodes and divides, registers the item and hands it through a two-deep
// command queue to the back, which first reads the bucket memory and then
// writes the updated count and loads the output register, waiting while
// the output register still holds a result that has not been popped. The
// back takes a new item only once it has finished with the one before.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_histogram_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_sample_value,
    input  wire logic [7:0]  i_bucket_index,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      o_bucket_count,
    output logic             o_is_last_bucket,
    output logic [31:0]      o_total_samples,
    output logic [31:0]      o_largest_sample
);

    import lhist_pkg::*;

    t_cmd front_cmd;
    logic front_push;
    logic q_full;
    t_cmd q_cmd;
    logic q_empty;
    logic q_pop;
    t_res res;

    // Decode and bucket selection
    lhist_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_action       (i_action),
        .i_sample_value (i_sample_value),
        .i_bucket_index (i_bucket_index),
        .o_cmd_push     (front_push),
        .o_cmd          (front_cmd),
        .i_cmd_full     (q_full)
    );

    // Command queue
    lhist_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // Execution against the bucket memory
    lhist_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_bucket_count   = res.count;
    assign o_is_last_bucket = res.last;
    assign o_total_samples  = res.total;
    assign o_largest_sample = res.peak;

endmodule

`default_nettype wire

>>> sv/lhist_ram.sv
// ----------------------------------------------------------------------------
// lhist_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lhist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/lhist_front.sv
// ----------------------------------------------------------------------------
// lhist_front
// Accepts items, decodes the action and works out the target bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module lhist_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [1:0]    i_action,
    input  wire logic [31:0]   i_sample_value,
    input  wire logic [7:0]    i_bucket_index,
    output logic               o_cmd_push,
    output lhist_pkg::t_cmd    o_cmd,
    input  wire logic          i_cmd_full
);

    import lhist_pkg::*;

    logic              r_vld;
    t_op               r_op;
    logic              r_big;
    logic [PROD_W-1:0] r_prod;
    logic [DATA_W-1:0] r_sample;
    logic [ADDR_W-1:0] r_raddr;
    logic              r_hit;
    logic              r_last;

    logic              accept;
    t_op               n_op;
    logic [PROD_W-1:0] n_prod;
    logic              n_hit;
    logic              n_last;

    // Handshake: stage drains into the command queue
    assign o_cmd_push = r_vld && !i_cmd_full;
    assign o_full     = r_vld && i_cmd_full;
    assign accept     = i_push && !o_full;

    // Action decode
    always_comb begin
        case (i_action)
            ACT_LOG:   n_op = OP_LOG;
            ACT_CLEAR: n_op = OP_CLEAR;
            ACT_READ:  n_op = OP_READ;
            default:   n_op = OP_NONE;
        endcase
    end

    // Quotient by reciprocal multiply on the low bits of the sample
    assign n_prod = PROD_W'(i_sample_value[LIM_W-1:0]) * PROD_W'(RECIP);

    // Read index range check and overflow-bucket flag
    assign n_hit  = 32'(i_bucket_index) < 32'(NUM_BUCKETS);
    assign n_last = n_hit && (32'(i_bucket_index) == 32'(NUM_BUCKETS - 1));

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_cmd_push) begin
            r_vld <= 1'b0;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= n_op;
            r_big    <= i_sample_value >= DATA_W'(LIMIT);
            r_prod   <= n_prod;
            r_sample <= i_sample_value;
            r_raddr  <= ADDR_W'(i_bucket_index);
            r_hit    <= n_hit;
            r_last   <= n_last;
        end
    end

    // Finish the bucket: shift the product, clamp large samples
    always_comb begin
        o_cmd.op     = r_op;
        o_cmd.sample = r_sample;
        o_cmd.hit    = r_hit;
        o_cmd.last   = r_last;
        if (r_op == OP_LOG) begin
            o_cmd.addr = r_big ? ADDR_W'(NUM_BUCKETS - 1) : r_prod[SHIFT +: ADDR_W];
        end else begin
            o_cmd.addr = r_raddr;
        end
    end

endmodule

`default_nettype wire

>>> sv/lhist_cmdq.sv
// ----------------------------------------------------------------------------
// lhist_cmdq
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "latency_histogram_core_defines.svh"

module lhist_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lhist_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output lhist_pkg::t_cmd    o_data,
    output logic               o_empty
);

    import lhist_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                            '0 : r_wr_ptr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                            '0 : r_rd_ptr + CMDQ_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CMDQ_CNT_W'(1);
                2'b01:   r_count <= r_count - CMDQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Checks
    `LH_CHECK(a_cmdq_count_bound, r_count <= CMDQ_CNT_W'(CMDQ_DEPTH), "cmd queue over-filled")
    `LH_CHECK_NEXT(a_cmdq_last_pop, do_pop && !do_push && (r_count == CMDQ_CNT_W'(1)), o_empty, "cmd queue not empty after last pop")

endmodule

`default_nettype wire

>>> sv/lhist_back.sv
// ----------------------------------------------------------------------------
// lhist_back
// Executes commands against the bucket memory and keeps total and peak.
// ----------------------------------------------------------------------------
`default_nettype none

`include "latency_histogram_core_defines.svh"

module lhist_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lhist_pkg::t_cmd i_cmd,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire logic          i_pop,
    output logic               o_empty,
    output lhist_pkg::t_res    o_res
);

    import lhist_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    t_cmd                   r_cmd;
    logic [NUM_BUCKETS-1:0] r_valid;
    logic [DATA_W-1:0]      r_total;
    logic [DATA_W-1:0]      r_peak;
    logic                   r_out_vld;
    t_res                   r_out;

    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] ram_wdata;
    logic              ram_we;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] n_total;
    logic [DATA_W-1:0] n_peak;
    logic              done;
    t_res              n_out;

    // Take a command when idle; its bucket is read in the same cycle
    assign o_cmd_pop = (r_state == ST_IDLE) && !i_cmd_empty;

    // Finish once the output register is free
    assign done = (r_state == ST_EXEC) && (!r_out_vld || i_pop);

    // Entries never written since reset or clear read as zero
    assign cur       = r_valid[r_cmd.addr] ? ram_rdata : '0;
    assign ram_wdata = cur + DATA_W'(1);
    assign ram_we    = done && (r_cmd.op == OP_LOG);

    lhist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cmd.addr),
        .i_wdata (ram_wdata),
        .i_re    (o_cmd_pop),
        .i_raddr (i_cmd.addr),
        .o_rdata (ram_rdata)
    );

    // Operation result
    always_comb begin
        n_total     = r_total;
        n_peak      = r_peak;
        n_out.count = '0;
        n_out.last  = 1'b0;
        case (r_cmd.op)
            OP_LOG: begin
                n_total = r_total + DATA_W'(1);
                if (r_cmd.sample > r_peak) begin
                    n_peak = r_cmd.sample;
                end
            end
            OP_CLEAR: begin
                n_total = '0;
                n_peak  = '0;
            end
            OP_READ: begin
                if (r_cmd.hit) begin
                    n_out.count = cur;
                    n_out.last  = r_cmd.last;
                end
            end
            default: begin
            end
        endcase
        n_out.total = n_total;
        n_out.peak  = n_peak;
    end

    // Sequencer
    always_comb begin
        case (r_state)
            ST_IDLE: n_state = o_cmd_pop ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = done ? ST_IDLE : ST_EXEC;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control state, totals and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_total   <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_total <= n_total;
                r_peak  <= n_peak;
                if (r_cmd.op == OP_LOG) begin
                    r_valid[r_cmd.addr] <= 1'b1;
                end else if (r_cmd.op == OP_CLEAR) begin
                    r_valid <= '0;
                end
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (done) begin
            r_out <= n_out;
        end
    end

    assign o_empty = !r_out_vld;
    assign o_res   = r_out;

    // Checks
    `LH_CHECK(a_back_state_onehot, $onehot(r_state), "back state not one-hot")
    `LH_CHECK_NEXT(a_back_pop_starts, o_cmd_pop, r_state == ST_EXEC, "command taken but not executing")
    `LH_CHECK_NEXT(a_back_clear, done && (r_cmd.op == OP_CLEAR), r_out_vld && (r_out.total == '0) && (r_out.peak == '0) && (r_valid == '0), "clear left state behind")
    `LH_CHECK_NEXT(a_back_peak_rises, !(done && (r_cmd.op == OP_CLEAR)), r_peak >= $past(r_peak), "peak fell without a clear")

endmodule

`default_nettype wire
